[hw/rtl/rtnp_pkg.sv]
// ----------------------------------------------------------------------------
// rtnp_pkg
// Shared types, widths and the constant palette for the nearest palette
// index pipeline.
// ----------------------------------------------------------------------------
package rtnp_pkg;

    localparam int NumLeaves = 256;
    localparam int DistW     = 18;
    localparam int IdxW      = 8;
    localparam int ChanW     = 8;

    typedef logic [DistW-1:0] t_dist;
    typedef logic [IdxW-1:0]  t_idx;
    typedef logic [ChanW-1:0] t_chan;

    typedef struct packed {
        logic valid;
        logic near_black;
    } t_ctl;

    localparam t_idx  NearBlackIdx = t_idx'(7);
    localparam t_chan NearBlackLim = t_chan'(8);
    // never beats a real entry, leaf 0 is not searched
    localparam t_dist DistMax      = '1;

    function automatic int scale_chan(input int v10, input int k8);
        return (51 * v10 * k8 + 8) / 16;
    endfunction

    // returns {blue, green, red}
    function automatic logic [3*ChanW-1:0] palette_entry(input int idx);
        int r, g, b, n, h, j, v10, s8, f4, sf8, p8, q8, t8, sx;
        int r8, g8, b8;
        logic [3*ChanW-1:0] res;
        r = 0; g = 0; b = 0;
        if (idx <= 9) begin
            case (idx)
                1: begin r = 255; g = 0; b = 0; end
                2: begin r = 255; g = 255; b = 0; end
                3: begin r = 0; g = 255; b = 0; end
                4: begin r = 0; g = 255; b = 255; end
                5: begin r = 0; g = 0; b = 255; end
                6: begin r = 255; g = 0; b = 255; end
                8: begin r = 128; g = 128; b = 128; end
                9: begin r = 192; g = 192; b = 192; end
                default: begin r = 0; g = 0; b = 0; end
            endcase
        end else if (idx >= 250) begin
            case (idx)
                250: r = 51;
                251: r = 91;
                252: r = 132;
                253: r = 173;
                254: r = 214;
                default: r = 255;
            endcase
            g = r; b = r;
        end else begin
            n = idx - 10;
            h = n / 10;
            j = n % 10;
            case (j / 2)
                0: v10 = 10;
                1: v10 = 8;
                2: v10 = 6;
                3: v10 = 5;
                default: v10 = 3;
            endcase
            s8  = (j % 2 != 0) ? 4 : 8;
            f4  = h % 4;
            sf8 = s8 * f4 / 4;
            p8  = 8 - s8;
            q8  = 8 - sf8;
            t8  = 8 - (s8 - sf8);
            sx  = h / 4;
            case (sx)
                0: begin r8 = 8;  g8 = t8; b8 = p8; end
                1: begin r8 = q8; g8 = 8;  b8 = p8; end
                2: begin r8 = p8; g8 = 8;  b8 = t8; end
                3: begin r8 = p8; g8 = q8; b8 = 8;  end
                4: begin r8 = t8; g8 = p8; b8 = 8;  end
                default: begin r8 = 8; g8 = p8; b8 = q8; end
            endcase
            r = scale_chan(v10, r8);
            g = scale_chan(v10, g8);
            b = scale_chan(v10, b8);
        end
        res = {b[ChanW-1:0], g[ChanW-1:0], r[ChanW-1:0]};
        return res;
    endfunction

endpackage

[hw/rtl/rtnp_dist.sv]
// ----------------------------------------------------------------------------
// rtnp_dist
// Squared distance from the colour to every palette entry but entry 0, which
// is held at DistMax, registered.
module rtnp_dist (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  rtnp_pkg::t_ctl                         i_ctl,
    input  rtnp_pkg::t_chan                        i_red,
    input  rtnp_pkg::t_chan                        i_green,
    input  rtnp_pkg::t_chan                        i_blue,
    output rtnp_pkg::t_ctl                         o_ctl,
    output rtnp_pkg::t_dist                        o_dist [rtnp_pkg::NumLeaves]
);
    import rtnp_pkg::*;

    t_ctl  r_ctl;
    t_dist r_dist [NumLeaves];
    t_dist n_dist [NumLeaves];

    function automatic t_dist sq_diff(input t_chan a, input t_chan b);
        t_chan ad;
        ad = (a >= b) ? t_chan'(a - b) : t_chan'(b - a);
        return t_dist'(ad) * t_dist'(ad);
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < NumLeaves; gi++) begin : g_ent
            localparam logic [3*ChanW-1:0] Pal = palette_entry(gi);
            if (gi == 0) begin : g_skip
                assign n_dist[gi] = DistMax;
            end else begin : g_calc
                assign n_dist[gi] = sq_diff(Pal[ChanW-1:0], i_red)
                                  + sq_diff(Pal[2*ChanW-1:ChanW], i_green)
                                  + sq_diff(Pal[3*ChanW-1:2*ChanW], i_blue);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= n_dist;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_dist = r_dist;

endmodule

[hw/rtl/rtnp_min4.sv]
// ----------------------------------------------------------------------------
// rtnp_min4
// Two levels of the minimum tree, four candidates into one, registered.
// ----------------------------------------------------------------------------
module rtnp_min4 #(
    parameter int NIn = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rtnp_pkg::t_ctl  i_ctl,
    input  rtnp_pkg::t_dist i_dist [NIn],
    input  rtnp_pkg::t_idx  i_idx  [NIn],
    output rtnp_pkg::t_ctl  o_ctl,
    output rtnp_pkg::t_dist o_dist [NIn/4],
    output rtnp_pkg::t_idx  o_idx  [NIn/4]
);
    import rtnp_pkg::*;

    localparam int NOut = NIn / 4;

    t_ctl  r_ctl;
    t_dist r_dist [NOut];
    t_idx  r_idx  [NOut];
    t_dist n_dist [NOut];
    t_idx  n_idx  [NOut];

    // left operand always has the lower index, it keeps ties
    always_comb begin
        t_dist d_a, d_b;
        t_idx  x_a, x_b;
        for (int k = 0; k < NOut; k++) begin
            d_a = i_dist[4*k];   x_a = i_idx[4*k];
            if (i_dist[4*k+1] < d_a) begin
                d_a = i_dist[4*k+1]; x_a = i_idx[4*k+1];
            end
            d_b = i_dist[4*k+2]; x_b = i_idx[4*k+2];
            if (i_dist[4*k+3] < d_b) begin
                d_b = i_dist[4*k+3]; x_b = i_idx[4*k+3];
            end
            if (d_b < d_a) begin
                n_dist[k] = d_b; n_idx[k] = x_b;
            end else begin
                n_dist[k] = d_a; n_idx[k] = x_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= n_dist;
            r_idx  <= n_idx;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_dist = r_dist;
    assign o_idx  = r_idx;

endmodule

[hw/rtl/rgb_to_nearest_palette_index_core.sv]
// ----------------------------------------------------------------------------
// rgb_to_nearest_palette_index_core
// Maps an RGB colour to the nearest entry of a fixed 256-colour palette.
// ----------------------------------------------------------------------------
// channel  direction  tdata fields (low bit up)
// s        in         red[7:0], green[15:8], blue[23:16]
// m        out        palette_index[7:0]
//
// one item per cycle sustained while the output is not stalled, six register
// stages: an input register, a distance stage for all 255 entries and four
// stages of a four-way minimum tree. all stages move together on one enable,
// so a stall at the output holds every stage in place. reset clears the
// control bits (valid and near black) only and holds the input not ready.
// ----------------------------------------------------------------------------
module rgb_to_nearest_palette_index_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red, green, blue
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // palette_index
);
    import rtnp_pkg::*;

    logic  w_en;
    t_ctl  r_in_ctl;
    t_ctl  n_in_ctl;
    t_chan r_red, r_green, r_blue;

    t_ctl  w_ctl_d, w_ctl_1, w_ctl_2, w_ctl_3, w_ctl_4;
    t_dist w_d0 [NumLeaves];
    t_idx  w_i0 [NumLeaves];
    t_dist w_d1 [NumLeaves/4];
    t_idx  w_i1 [NumLeaves/4];
    t_dist w_d2 [NumLeaves/16];
    t_idx  w_i2 [NumLeaves/16];
    t_dist w_d3 [NumLeaves/64];
    t_idx  w_i3 [NumLeaves/64];
    t_dist w_d4 [1];
    t_idx  w_i4 [1];

    assign w_en       = !w_ctl_4.valid || i_m_tready;
    assign o_s_tready = w_en && i_rst_n;

    always_comb begin
        n_in_ctl.valid      = i_s_tvalid;
        n_in_ctl.near_black = (i_s_tdata[7:0] < NearBlackLim)
                           && (i_s_tdata[15:8] < NearBlackLim)
                           && (i_s_tdata[23:16] < NearBlackLim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_en) begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_red   <= i_s_tdata[7:0];
            r_green <= i_s_tdata[15:8];
            r_blue  <= i_s_tdata[23:16];
        end
    end

    rtnp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_in_ctl),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_ctl   (w_ctl_d),
        .o_dist  (w_d0)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NumLeaves; gi++) begin : g_leaf
            assign w_i0[gi] = t_idx'(gi);
        end
    endgenerate

    rtnp_min4 #(.NIn(NumLeaves)) u_min_1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_ctl (w_ctl_d), .i_dist (w_d0), .i_idx (w_i0),
        .o_ctl (w_ctl_1), .o_dist (w_d1), .o_idx (w_i1)
    );

    rtnp_min4 #(.NIn(NumLeaves/4)) u_min_2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_ctl (w_ctl_1), .i_dist (w_d1), .i_idx (w_i1),
        .o_ctl (w_ctl_2), .o_dist (w_d2), .o_idx (w_i2)
    );

    rtnp_min4 #(.NIn(NumLeaves/16)) u_min_3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_ctl (w_ctl_2), .i_dist (w_d2), .i_idx (w_i2),
        .o_ctl (w_ctl_3), .o_dist (w_d3), .o_idx (w_i3)
    );

    rtnp_min4 #(.NIn(NumLeaves/64)) u_min_4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_ctl (w_ctl_3), .i_dist (w_d3), .i_idx (w_i3),
        .o_ctl (w_ctl_4), .o_dist (w_d4), .o_idx (w_i4)
    );

    assign o_m_tvalid = w_ctl_4.valid;
    // near black, or a search that found no real entry, bypasses the search result
    assign o_m_tdata  = (w_ctl_4.near_black || (w_d4[0] == DistMax)) ? NearBlackIdx
                                                                       : w_i4[0];

endmodule
